[rtl/fpd_pkg.sv]
`timescale 1ns / 1ps
// Package for the framed packet deframer: phase and event codes, register
// indexes, reset values, result type and the CRC-16/ARC byte step.
// No dependencies.
package fpd_pkg;

    localparam int MAX_PAYLOAD_BYTES_DEF = 8192;

    localparam int SYNC_W = 8;
    localparam int LEN_W  = 14;
    localparam int CFG_W  = 14;
    localparam int IDX_W  = 2;

    localparam logic [IDX_W-1:0] REG_SYNC_FIRST  = 2'd0;
    localparam logic [IDX_W-1:0] REG_SYNC_SECOND = 2'd1;
    localparam logic [IDX_W-1:0] REG_MAX_LEN     = 2'd2;

    localparam logic [SYNC_W-1:0] SYNC_FIRST_RST  = 8'h61;
    localparam logic [SYNC_W-1:0] SYNC_SECOND_RST = 8'h6D;
    localparam logic [LEN_W-1:0]  MAX_LEN_RST     = 14'd8192;

    localparam logic [LEN_W-1:0] LEN_FIELD_MAX = 14'h3FFF;

    localparam logic [15:0] CRC_INIT = 16'h0000;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic [3:0] PH_SYNC0   = 4'd0;
    localparam logic [3:0] PH_SYNC1   = 4'd1;
    localparam logic [3:0] PH_LEN0    = 4'd2;
    localparam logic [3:0] PH_LEN1    = 4'd3;
    localparam logic [3:0] PH_LEN2    = 4'd4;
    localparam logic [3:0] PH_LEN3    = 4'd5;
    localparam logic [3:0] PH_MSGID   = 4'd6;
    localparam logic [3:0] PH_SENDER  = 4'd7;
    localparam logic [3:0] PH_PAYLOAD = 4'd8;
    localparam logic [3:0] PH_CRC0    = 4'd9;
    localparam logic [3:0] PH_CRC1    = 4'd10;

    localparam logic [2:0] EV_HEADER  = 3'd0;
    localparam logic [2:0] EV_PAYLOAD = 3'd1;
    localparam logic [2:0] EV_GOOD    = 3'd2;
    localparam logic [2:0] EV_BAD_CRC = 3'd3;
    localparam logic [2:0] EV_LEN_REJ = 3'd4;

    localparam logic ACT_BYTE  = 1'b0;
    localparam logic ACT_FLUSH = 1'b1;

    typedef struct packed {
        logic [SYNC_W-1:0] sync_first;
        logic [SYNC_W-1:0] sync_second;
        logic [LEN_W-1:0]  max_len;
    } cfg_t;

    typedef struct packed {
        logic [2:0]       event_res;
        logic [7:0]       payload_byte;
        logic [7:0]       message_id;
        logic [7:0]       sender_id;
        logic [LEN_W-1:0] frame_length;
        logic             frame_end;
    } result_t;

    function automatic logic [15:0] crc16_arc_byte(input logic [15:0] crc,
                                                   input logic [7:0]  data);
        logic [15:0] c;
        c = crc ^ {8'h00, data};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

[rtl/fpd_cfg_regs.sv]
`timescale 1ns / 1ps
// Configuration registers of the deframer: sync bytes and payload length limit.
// Depends on fpd_pkg.
module fpd_cfg_regs (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_we,
    input  logic [fpd_pkg::IDX_W-1:0] cfg_addr,
    input  logic [fpd_pkg::CFG_W-1:0] cfg_wdata,
    output fpd_pkg::cfg_t             cfg
);

    fpd_pkg::cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sync_first  <= fpd_pkg::SYNC_FIRST_RST;
            cfg_reg.sync_second <= fpd_pkg::SYNC_SECOND_RST;
            cfg_reg.max_len     <= fpd_pkg::MAX_LEN_RST;
        end else if (cfg_we) begin
            if (cfg_addr == fpd_pkg::REG_SYNC_FIRST) begin
                cfg_reg.sync_first <= cfg_wdata[fpd_pkg::SYNC_W-1:0];
            end
            if (cfg_addr == fpd_pkg::REG_SYNC_SECOND) begin
                cfg_reg.sync_second <= cfg_wdata[fpd_pkg::SYNC_W-1:0];
            end
            if (cfg_addr == fpd_pkg::REG_MAX_LEN) begin
                cfg_reg.max_len <= cfg_wdata[fpd_pkg::LEN_W-1:0];
            end
        end
    end

    assign cfg = cfg_reg;

endmodule

[rtl/fpd_parser.sv]
`timescale 1ns / 1ps
// Input word register and frame parser: sync hunt, header, payload count and
// CRC-16/ARC check, one word per cycle while proc_ready is high. Depends on fpd_pkg.
module fpd_parser #(
    parameter int MAX_PAYLOAD_BYTES = fpd_pkg::MAX_PAYLOAD_BYTES_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic                    s_action,
    input  logic [7:0]              s_rx_byte,
    input  fpd_pkg::cfg_t           cfg,
    input  logic                    proc_ready,
    output logic                    res_valid,
    output fpd_pkg::result_t        res
);

    logic                      in_valid_reg;
    logic                      in_action_reg;
    logic [7:0]                in_byte_reg;

    logic [3:0]                phase_reg, phase_next;
    logic [31:0]               length_reg, length_next;
    logic [fpd_pkg::LEN_W-1:0] count_reg, count_next;
    logic [7:0]                msg_id_reg, msg_id_next;
    logic [7:0]                sender_reg, sender_next;
    logic [15:0]               crc_reg, crc_next;
    logic [7:0]                crc_low_reg, crc_low_next;

    logic                      fire;
    logic [15:0]               crc_step;
    logic [31:0]               len_shifted;
    logic [fpd_pkg::LEN_W-1:0] count_inc;
    logic                      over_limit;

    assign s_ready = !in_valid_reg || proc_ready;
    assign fire    = in_valid_reg && proc_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_action_reg <= s_action;
            in_byte_reg   <= s_rx_byte;
        end
    end

    assign crc_step    = fpd_pkg::crc16_arc_byte(crc_reg, in_byte_reg);
    assign len_shifted = {in_byte_reg, length_reg[31:8]};
    assign count_inc   = count_reg + 1'b1;
    assign over_limit  = (len_shifted > {18'd0, cfg.max_len})
                      || (len_shifted > 32'(MAX_PAYLOAD_BYTES));

    always_comb begin
        phase_next   = phase_reg;
        length_next  = length_reg;
        count_next   = count_reg;
        msg_id_next  = msg_id_reg;
        sender_next  = sender_reg;
        crc_next     = crc_reg;
        crc_low_next = crc_low_reg;
        res_valid    = 1'b0;
        res          = '0;
        if (in_action_reg == fpd_pkg::ACT_FLUSH) begin
            phase_next = fpd_pkg::PH_SYNC0;
        end else begin
            unique case (phase_reg)
                fpd_pkg::PH_SYNC1: begin
                    if (in_byte_reg == cfg.sync_second) begin
                        crc_next    = crc_step;
                        length_next = '0;
                        count_next  = '0;
                        phase_next  = fpd_pkg::PH_LEN0;
                    end else if (in_byte_reg == cfg.sync_first) begin
                        crc_next   = fpd_pkg::crc16_arc_byte(fpd_pkg::CRC_INIT,
                                                             in_byte_reg);
                        phase_next = fpd_pkg::PH_SYNC1;
                    end else begin
                        phase_next = fpd_pkg::PH_SYNC0;
                    end
                end
                fpd_pkg::PH_LEN0, fpd_pkg::PH_LEN1, fpd_pkg::PH_LEN2: begin
                    crc_next    = crc_step;
                    length_next = len_shifted;
                    phase_next  = phase_reg + 4'd1;
                end
                fpd_pkg::PH_LEN3: begin
                    crc_next    = crc_step;
                    length_next = len_shifted;
                    if (over_limit) begin
                        phase_next    = fpd_pkg::PH_SYNC0;
                        res_valid     = 1'b1;
                        res.event_res = fpd_pkg::EV_LEN_REJ;
                        res.frame_end = 1'b1;
                        res.frame_length = (len_shifted > {18'd0, fpd_pkg::LEN_FIELD_MAX})
                                         ? fpd_pkg::LEN_FIELD_MAX
                                         : len_shifted[fpd_pkg::LEN_W-1:0];
                    end else begin
                        phase_next = fpd_pkg::PH_MSGID;
                    end
                end
                fpd_pkg::PH_MSGID: begin
                    crc_next    = crc_step;
                    msg_id_next = in_byte_reg;
                    phase_next  = fpd_pkg::PH_SENDER;
                end
                fpd_pkg::PH_SENDER: begin
                    crc_next    = crc_step;
                    sender_next = in_byte_reg;
                    count_next  = '0;
                    phase_next  = (length_reg == 32'd0) ? fpd_pkg::PH_CRC0
                                                        : fpd_pkg::PH_PAYLOAD;
                    res_valid        = 1'b1;
                    res.event_res    = fpd_pkg::EV_HEADER;
                    res.message_id   = msg_id_reg;
                    res.sender_id    = in_byte_reg;
                    res.frame_length = length_reg[fpd_pkg::LEN_W-1:0];
                end
                fpd_pkg::PH_PAYLOAD: begin
                    crc_next   = crc_step;
                    count_next = count_inc;
                    if ({18'd0, count_inc} >= length_reg) begin
                        phase_next = fpd_pkg::PH_CRC0;
                    end
                    res_valid        = 1'b1;
                    res.event_res    = fpd_pkg::EV_PAYLOAD;
                    res.payload_byte = in_byte_reg;
                    res.message_id   = msg_id_reg;
                    res.sender_id    = sender_reg;
                    res.frame_length = length_reg[fpd_pkg::LEN_W-1:0];
                end
                fpd_pkg::PH_CRC0: begin
                    crc_low_next = in_byte_reg;
                    phase_next   = fpd_pkg::PH_CRC1;
                end
                fpd_pkg::PH_CRC1: begin
                    phase_next       = fpd_pkg::PH_SYNC0;
                    res_valid        = 1'b1;
                    res.event_res    = ({in_byte_reg, crc_low_reg} == crc_reg)
                                     ? fpd_pkg::EV_GOOD : fpd_pkg::EV_BAD_CRC;
                    res.message_id   = msg_id_reg;
                    res.sender_id    = sender_reg;
                    res.frame_length = length_reg[fpd_pkg::LEN_W-1:0];
                    res.frame_end    = 1'b1;
                end
                default: begin
                    phase_next = fpd_pkg::PH_SYNC0;
                    if (in_byte_reg == cfg.sync_first) begin
                        crc_next   = fpd_pkg::crc16_arc_byte(fpd_pkg::CRC_INIT,
                                                             in_byte_reg);
                        phase_next = fpd_pkg::PH_SYNC1;
                    end
                end
            endcase
        end
        if (!fire) begin
            res_valid = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= fpd_pkg::PH_SYNC0;
            length_reg  <= '0;
            count_reg   <= '0;
            msg_id_reg  <= '0;
            sender_reg  <= '0;
            crc_reg     <= fpd_pkg::CRC_INIT;
            crc_low_reg <= '0;
        end else if (fire) begin
            phase_reg   <= phase_next;
            length_reg  <= length_next;
            count_reg   <= count_next;
            msg_id_reg  <= msg_id_next;
            sender_reg  <= sender_next;
            crc_reg     <= crc_next;
            crc_low_reg <= crc_low_next;
        end
    end

endmodule

[rtl/framed_packet_deframer_crc16_core.sv]
`timescale 1ns / 1ps
// Top level of the length-prefixed frame deframer with CRC-16/ARC check.
// Depends on fpd_pkg, fpd_cfg_regs and fpd_parser.
//
// The block takes one received word (or a flush) per cycle and gives at most
// one event per word. A word goes into an input register, is parsed by one
// pass of logic that includes an eight-step CRC-16/ARC update, and its
// event, if any, lands in the output register, from which the result is
// offered. The input register and the output register each take a new word
// when empty or when their content moves on, so the sustained rate is one
// word per cycle as long as the result side keeps up. Payload words are
// passed on before the CRC is checked; a frame that ends with a bad CRC
// event should be dropped downstream.
module framed_packet_deframer_crc16_core #(
    parameter int MAX_PAYLOAD_BYTES = fpd_pkg::MAX_PAYLOAD_BYTES_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_we,
    input  logic [fpd_pkg::IDX_W-1:0] cfg_addr,
    input  logic [fpd_pkg::CFG_W-1:0] cfg_wdata,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic                      s_action,
    input  logic [7:0]                s_rx_byte,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [2:0]                m_event_res,
    output logic [7:0]                m_payload_byte,
    output logic [7:0]                m_message_id,
    output logic [7:0]                m_sender_id,
    output logic [fpd_pkg::LEN_W-1:0] m_frame_length,
    output logic                      m_frame_end
);

    fpd_pkg::cfg_t    cfg;
    fpd_pkg::result_t res;
    fpd_pkg::result_t out_reg;
    logic             res_valid;
    logic             out_valid_reg;
    logic             proc_ready;

    fpd_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    fpd_parser #(
        .MAX_PAYLOAD_BYTES (MAX_PAYLOAD_BYTES)
    ) u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_action   (s_action),
        .s_rx_byte  (s_rx_byte),
        .cfg        (cfg),
        .proc_ready (proc_ready),
        .res_valid  (res_valid),
        .res        (res)
    );

    assign proc_ready = !out_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (proc_ready) begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            out_reg <= res;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_event_res    = out_reg.event_res;
    assign m_payload_byte = out_reg.payload_byte;
    assign m_message_id   = out_reg.message_id;
    assign m_sender_id    = out_reg.sender_id;
    assign m_frame_length = out_reg.frame_length;
    assign m_frame_end    = out_reg.frame_end;

    a_end_matches_event: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_frame_end == ((m_event_res == fpd_pkg::EV_GOOD)
                                  || (m_event_res == fpd_pkg::EV_BAD_CRC)
                                  || (m_event_res == fpd_pkg::EV_LEN_REJ))))
        else $error("frame end flag disagrees with event code");

    a_payload_only_on_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_event_res != fpd_pkg::EV_PAYLOAD)) |-> (m_payload_byte == 8'd0))
        else $error("payload byte set on a non-payload event");

    a_reject_clears_ids: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_event_res == fpd_pkg::EV_LEN_REJ))
            |-> ((m_message_id == 8'd0) && (m_sender_id == 8'd0)))
        else $error("ids set on a length reject event");

    a_length_in_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_event_res != fpd_pkg::EV_LEN_REJ))
            |-> ({18'd0, m_frame_length} <= 32'(MAX_PAYLOAD_BYTES)))
        else $error("accepted frame length above the build limit");

endmodule
